[sv/pfr_pkg.sv]
`default_nettype none
package pfr_pkg;

	// Geometry limits
	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int PALETTE_DEPTH = 256;

	// Field widths fixed by the stream format
	localparam int DIM_W   = 11;
	localparam int COLOR_W = 16;
	localparam int INDEX_W = 8;
	localparam int FMT_W   = 2;
	localparam int REG_W   = 2;

	// Counter and clamped-dimension widths
	localparam int COL_W  = ($clog2(MAX_WIDTH) > 0) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = ($clog2(MAX_HEIGHT) > 0) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WDIM_W = COL_W + 1;
	localparam int HDIM_W = ROW_W + 1;

	localparam logic [COLOR_W-1:0] MONO_SET_COLOR   = 16'h0000;
	localparam logic [COLOR_W-1:0] MONO_CLEAR_COLOR = 16'hFFFF;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(160);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(160);

	typedef enum logic [FMT_W-1:0] {
		FMT_MONO    = 2'd0,
		FMT_INDEXED = 2'd1,
		FMT_DIRECT  = 2'd2
	} fmt_t;

	typedef enum logic [REG_W-1:0] {
		REG_FORMAT = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_PALETTE = 1'b0,
		OP_DATA    = 1'b1
	} opcode_t;

	// Raster position flags for the pixel about to be emitted
	typedef struct packed {
		logic end_of_row;
		logic end_of_frame;
	} raster_t;

	function automatic logic [WDIM_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
		if (v == '0) return WDIM_W'(1);
		if (32'(v) > 32'(MAX_WIDTH)) return WDIM_W'(MAX_WIDTH);
		return WDIM_W'(v);
	endfunction

	function automatic logic [HDIM_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
		if (v == '0) return HDIM_W'(1);
		if (32'(v) > 32'(MAX_HEIGHT)) return HDIM_W'(MAX_HEIGHT);
		return HDIM_W'(v);
	endfunction

endpackage
`default_nettype wire

[sv/pfr_in_if.sv]
`default_nettype none
interface pfr_in_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [pfr_pkg::INDEX_W-1:0]  palette_index;
	logic [pfr_pkg::COLOR_W-1:0]  palette_color;
	logic [pfr_pkg::COLOR_W-1:0]  data_word;

	modport source (output valid, opcode, palette_index, palette_color, data_word,
		input ready);
	modport sink (input valid, opcode, palette_index, palette_color, data_word,
		output ready);
endinterface
`default_nettype wire

[sv/pfr_out_if.sv]
`default_nettype none
interface pfr_out_if;
	logic                         valid;
	logic                         ready;
	logic [pfr_pkg::COLOR_W-1:0]  pixel_color;
	logic                         last_of_item;
	logic                         end_of_row;
	logic                         end_of_frame;

	modport source (output valid, pixel_color, last_of_item, end_of_row, end_of_frame,
		input ready);
	modport sink (input valid, pixel_color, last_of_item, end_of_row, end_of_frame,
		output ready);
endinterface
`default_nettype wire

[sv/pfr_ram.sv]
`default_nettype none
module pfr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[sv/pfr_raster.sv]
`default_nettype none
module pfr_raster (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         clear,
	input  wire logic                         advance,
	input  wire logic [pfr_pkg::DIM_W-1:0]    image_width,
	input  wire logic [pfr_pkg::DIM_W-1:0]    image_height,
	output pfr_pkg::raster_t                  status
);

	logic [pfr_pkg::COL_W-1:0]  col_q;
	logic [pfr_pkg::ROW_W-1:0]  row_q;
	logic [pfr_pkg::WDIM_W-1:0] width_c;
	logic [pfr_pkg::HDIM_W-1:0] height_c;
	logic [pfr_pkg::WDIM_W-1:0] col_next;
	logic [pfr_pkg::HDIM_W-1:0] row_next;

	always_comb begin
		width_c  = pfr_pkg::clamp_width(image_width);
		height_c = pfr_pkg::clamp_height(image_height);
		col_next = {1'b0, col_q} + pfr_pkg::WDIM_W'(1);
		row_next = {1'b0, row_q} + pfr_pkg::HDIM_W'(1);
		status.end_of_row   = (col_next >= width_c);
		status.end_of_frame = status.end_of_row && (row_next >= height_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (status.end_of_row) begin
				col_q <= '0;
				row_q <= status.end_of_frame ? '0 : row_next[pfr_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_next[pfr_pkg::COL_W-1:0];
			end
		end
	end

	// Column stays inside the row once the geometry settles
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		($past(clear) || $past(advance)) |-> ({1'b0, col_q} < width_c))
		else $error("column counter ran past the row width");

	// Row stays inside the frame once the geometry settles
	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		($past(clear) || $past(advance)) |-> ({1'b0, row_q} < height_c))
		else $error("row counter ran past the frame height");

	// Frame end is always a row end
	a_eof_is_eor: assert property (@(posedge clk) disable iff (!arst_n)
		status.end_of_frame |-> status.end_of_row)
		else $error("frame end flagged inside a row");

endmodule
`default_nettype wire

[sv/pixel_format_to_rgb565.sv]
`default_nettype none
// Channel    Role    Payload                                             Handshake
// pixel_in   sink    opcode, palette_index, palette_color, data_word     valid/ready
// pixel_out  source  pixel_color, last_of_item, end_of_row, end_of_frame valid/ready
// cfg        write   cfg_index selects format/width/height, cfg_data    cfg_we, no wait
//
// Throughput, while pixel_out is ready: one transaction in per cycle for palette writes,
//   8bpp and 16bpp data; a 1bpp byte occupies the expansion stage for one to eight pixels,
//   one per cycle, ending early at row end. One pixel leaves per cycle.
// Path: a transaction loads the expansion stage at its accepting edge, with the palette
//   read at that edge; its first pixel then goes through the output register to pixel_out.
// Reset: arst_n clears control state and counters; the palette holds garbage until written.
// Stalls: an empty output register lets the stage advance regardless of pixel_out.ready;
//   a full one waiting on pixel_out.ready holds the stage and pixel_in.ready the same cycle.
module pixel_format_to_rgb565 (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	pfr_in_if.sink                          pixel_in,
	pfr_out_if.source                       pixel_out,
	input  wire logic                       cfg_we,
	input  wire logic [pfr_pkg::REG_W-1:0]  cfg_index,
	input  wire logic [pfr_pkg::DIM_W-1:0]  cfg_data
);

	// Configuration registers
	pfr_pkg::fmt_t              fmt_q;
	logic [pfr_pkg::FMT_W-1:0]  fmt_raw_q;
	logic [pfr_pkg::DIM_W-1:0]  width_q;
	logic [pfr_pkg::DIM_W-1:0]  height_q;
	logic                       cfg_hit;

	// Expansion stage: holds one data transaction while its pixels drain
	logic                          valid_s1;
	logic [pfr_pkg::COLOR_W-1:0]   data_s1;
	logic [7:0]                    byte_s1;
	logic [2:0]                    bit_s1;

	// Output register
	logic                          out_valid_q;
	logic [pfr_pkg::COLOR_W-1:0]   out_color_q;
	logic                          out_last_q;
	logic                          out_eor_q;
	logic                          out_eof_q;

	logic                          accept;
	logic                          is_data;
	logic                          fmt_known;
	logic                          load_s1;
	logic                          advance;
	logic                          last_c;
	logic                          s1_done;
	logic [pfr_pkg::COLOR_W-1:0]   color_c;
	logic [pfr_pkg::COLOR_W-1:0]   pal_rdata;
	logic                          pal_we;
	logic                          pal_re;
	pfr_pkg::raster_t              raster;

	assign fmt_q = pfr_pkg::fmt_t'(fmt_raw_q);

	// Decode a write; an index past the register list is dropped
	always_comb begin
		unique case (pfr_pkg::reg_idx_t'(cfg_index))
			pfr_pkg::REG_FORMAT,
			pfr_pkg::REG_WIDTH,
			pfr_pkg::REG_HEIGHT: cfg_hit = cfg_we;
			default:             cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_raw_q <= pfr_pkg::FMT_MONO;
			width_q   <= pfr_pkg::WIDTH_RESET;
			height_q  <= pfr_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (pfr_pkg::reg_idx_t'(cfg_index))
				pfr_pkg::REG_FORMAT: fmt_raw_q <= cfg_data[pfr_pkg::FMT_W-1:0];
				pfr_pkg::REG_WIDTH:  width_q   <= cfg_data;
				pfr_pkg::REG_HEIGHT: height_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Format code three has no meaning: its data transactions are swallowed
	always_comb begin
		unique case (fmt_q)
			pfr_pkg::FMT_MONO,
			pfr_pkg::FMT_INDEXED,
			pfr_pkg::FMT_DIRECT: fmt_known = 1'b1;
			default:             fmt_known = 1'b0;
		endcase
	end

	// Pixel selection and end-of-transaction detection. A mono byte ends on its
	// eighth bit or at row end, whichever comes first.
	always_comb begin
		case (fmt_q)
			pfr_pkg::FMT_MONO: begin
				color_c = byte_s1[7] ? pfr_pkg::MONO_SET_COLOR : pfr_pkg::MONO_CLEAR_COLOR;
				last_c  = (bit_s1 == 3'd7) || raster.end_of_row;
			end
			pfr_pkg::FMT_INDEXED: begin
				color_c = pal_rdata;
				last_c  = 1'b1;
			end
			default: begin
				color_c = data_s1;
				last_c  = 1'b1;
			end
		endcase
	end

	// Handshake: the stage moves a pixel when the output register is free or draining
	assign advance         = valid_s1 && (!out_valid_q || pixel_out.ready);
	assign s1_done         = advance && last_c;
	assign pixel_in.ready  = !valid_s1 || s1_done;
	assign accept          = pixel_in.valid && pixel_in.ready;
	assign is_data         = (pfr_pkg::opcode_t'(pixel_in.opcode) == pfr_pkg::OP_DATA);
	assign load_s1         = accept && is_data && fmt_known;

	// Palette: write on a palette transaction, read on an indexed data transaction.
	// Only one transaction is taken per cycle, so a write and a read never collide,
	// and a write lands before any later read is issued. The read data holds while
	// the stage stalls because no new read issues until the stage is released.
	assign pal_we = accept && !is_data;
	assign pal_re = load_s1 && (fmt_q == pfr_pkg::FMT_INDEXED);

	pfr_ram #(
		.WIDTH (pfr_pkg::COLOR_W),
		.DEPTH (pfr_pkg::PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pixel_in.palette_index),
		.wdata (pixel_in.palette_color),
		.re    (pal_re),
		.raddr (pixel_in.data_word[pfr_pkg::INDEX_W-1:0]),
		.rdata (pal_rdata)
	);

	// Column/row tracking; any register write restarts the frame
	pfr_raster u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (cfg_hit),
		.advance      (advance),
		.image_width  (width_q),
		.image_height (height_q),
		.status       (raster)
	);

	// Expansion stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	// Expansion stage payload: load fresh, or shift to the next mono bit
	always_ff @(posedge clk) begin
		if (load_s1) begin
			data_s1 <= pixel_in.data_word;
			byte_s1 <= pixel_in.data_word[7:0];
			bit_s1  <= 3'd0;
		end else if (advance) begin
			byte_s1 <= {byte_s1[6:0], 1'b0};
			bit_s1  <= bit_s1 + 3'd1;
		end
	end

	// Output register: hold while stalled, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pixel_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_color_q <= color_c;
			out_last_q  <= last_c;
			out_eor_q   <= raster.end_of_row;
			out_eof_q   <= raster.end_of_frame;
		end
	end

	assign pixel_out.valid        = out_valid_q;
	assign pixel_out.pixel_color  = out_color_q;
	assign pixel_out.last_of_item = out_last_q;
	assign pixel_out.end_of_row   = out_eor_q;
	assign pixel_out.end_of_frame = out_eof_q;

	// A stalled stage keeps its transaction
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !pixel_out.ready) |=> valid_s1)
		else $error("expansion stage lost a transaction under stall");

	// A pixel that is not the last of its transaction keeps the stage busy
	a_s1_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !last_c) |=> (valid_s1 && !pixel_in.ready || valid_s1))
		else $error("mono byte dropped before its last pixel");

	// Frame end only coincides with row end
	a_eof_eor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_eof_q || out_eor_q))
		else $error("end of frame without end of row");

	// Input is refused only while the stage holds work
	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_in.ready |-> valid_s1)
		else $error("input stalled with an empty expansion stage");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;

	localparam int CLK_HALF      = 10;
	localparam int RANDOM_ITEMS  = 240;
	// The last pixel is loaded into the output register as the stage drains; leave a margin
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 400000;
	// Format code the block has no conversion for: data is dropped
	localparam logic [pfr_pkg::FMT_W-1:0] FMT_UNUSED = 2'd3;

	// One input transaction as the predictor sees it
	typedef struct packed {
		pfr_pkg::opcode_t                 opcode;
		logic [pfr_pkg::INDEX_W-1:0]      palette_index;
		logic [pfr_pkg::COLOR_W-1:0]      palette_color;
		logic [pfr_pkg::COLOR_W-1:0]      data_word;
	} src_item_t;

	// One output pixel transaction
	typedef struct packed {
		logic [pfr_pkg::COLOR_W-1:0]      pixel_color;
		logic                             last_of_item;
		logic                             end_of_row;
		logic                             end_of_frame;
	} pixel_t;

	// Tracks palette, raster position and geometry, and holds the pixels still owed
	class rgb565_scoreboard;
		logic [pfr_pkg::COLOR_W-1:0] palette [pfr_pkg::PALETTE_DEPTH];
		logic [pfr_pkg::FMT_W-1:0]   fmt_reg;
		logic [pfr_pkg::DIM_W-1:0]   width_reg;
		logic [pfr_pkg::DIM_W-1:0]   height_reg;
		int                          col;
		int                          row;
		pixel_t                      pixels_due [$];
		int                          mismatches;

		function new();
			fmt_reg    = pfr_pkg::FMT_MONO;
			width_reg  = pfr_pkg::WIDTH_RESET;
			height_reg = pfr_pkg::HEIGHT_RESET;
			col        = 0;
			row        = 0;
			mismatches = 0;
		endfunction

		// Zero means one; anything past the limit saturates
		function int extent(logic [pfr_pkg::DIM_W-1:0] v, int limit);
			if (v == '0) return 1;
			if (int'(v) > limit) return limit;
			return int'(v);
		endfunction

		function void write_reg(pfr_pkg::reg_idx_t idx, logic [pfr_pkg::DIM_W-1:0] val);
			case (idx)
				pfr_pkg::REG_FORMAT: fmt_reg = val[pfr_pkg::FMT_W-1:0];
				pfr_pkg::REG_WIDTH:  width_reg = val;
				pfr_pkg::REG_HEIGHT: height_reg = val;
				default: return;
			endcase
			// Any register write restarts the raster
			col = 0;
			row = 0;
		endfunction

		function void emit(logic [pfr_pkg::COLOR_W-1:0] color, logic last);
			pixel_t p;
			p.pixel_color  = color;
			p.last_of_item = last;
			p.end_of_row   = (col + 1 >= extent(width_reg, pfr_pkg::MAX_WIDTH));
			p.end_of_frame = p.end_of_row &&
				(row + 1 >= extent(height_reg, pfr_pkg::MAX_HEIGHT));
			if (p.end_of_row) begin
				col = 0;
				row = p.end_of_frame ? 0 : row + 1;
			end else begin
				col++;
			end
			pixels_due.push_back(p);
		endfunction

		function void note_item(src_item_t it);
			int         span;
			int         count;
			int         i;
			logic [7:0] bits;
			if (it.opcode == pfr_pkg::OP_PALETTE) begin
				palette[it.palette_index] = it.palette_color;
				return;
			end
			case (fmt_reg)
				pfr_pkg::FMT_MONO: begin
					// Short last byte of a row: only the pixels left in the row, MSB first
					span  = extent(width_reg, pfr_pkg::MAX_WIDTH);
					count = (col < span) ? span - col : 1;
					if (count > 8) count = 8;
					bits = it.data_word[7:0];
					for (i = 0; i < count; i++)
						emit(bits[7-i] ? pfr_pkg::MONO_SET_COLOR : pfr_pkg::MONO_CLEAR_COLOR,
							i == count - 1);
				end
				pfr_pkg::FMT_INDEXED: emit(palette[it.data_word[7:0]], 1'b1);
				pfr_pkg::FMT_DIRECT:  emit(it.data_word, 1'b1);
				default: ;
			endcase
		endfunction

		task report(string msg);
			mismatches++;
			$display("mismatch: %s", msg);
		endtask

		task check_pixel(pixel_t got);
			pixel_t want;
			if (pixels_due.size() == 0) begin
				report($sformatf("pixel %h arrived with nothing owed", got.pixel_color));
				return;
			end
			want = pixels_due.pop_front();
			if (got.pixel_color !== want.pixel_color)
				report($sformatf("pixel_color %h, want %h", got.pixel_color, want.pixel_color));
			if (got.last_of_item !== want.last_of_item)
				report($sformatf("last_of_item %b, want %b", got.last_of_item,
					want.last_of_item));
			if (got.end_of_row !== want.end_of_row)
				report($sformatf("end_of_row %b, want %b", got.end_of_row, want.end_of_row));
			if (got.end_of_frame !== want.end_of_frame)
				report($sformatf("end_of_frame %b, want %b", got.end_of_frame,
					want.end_of_frame));
		endtask

		function int pending();
			return pixels_due.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	pfr_pkg::reg_idx_t             cfg_index;
	logic [pfr_pkg::DIM_W-1:0]     cfg_data;

	pfr_in_if  pix_in ();
	pfr_out_if pix_out ();

	rgb565_scoreboard sb = new();

	// Palette entries written so far; indexed data only ever points at these
	bit                            palette_written [pfr_pkg::PALETTE_DEPTH];
	logic [pfr_pkg::INDEX_W-1:0]   written_idx [$];
	logic [pfr_pkg::FMT_W-1:0]     cur_fmt;
	int                            accepted;
	int                            in_calm;
	int                            out_calm;
	int                            cycle_count;

	pixel_format_to_rgb565 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel_in  (pix_in),
		.pixel_out (pix_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop: a hung handshake or a lost pixel ends here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Wait per transaction: mostly random, with occasional runs of back-to-back
	// transactions so that full-rate streaming gets exercised too
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	// Geometry values off the beaten path: zero, one, the maximum, past the maximum
	function automatic logic [pfr_pkg::DIM_W-1:0] odd_dim();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return pfr_pkg::DIM_W'(1);
			2: return pfr_pkg::DIM_W'(pfr_pkg::MAX_WIDTH);
			3: return '1;
			default: return pfr_pkg::DIM_W'($urandom_range(pfr_pkg::MAX_WIDTH + 1, 2047));
		endcase
	endfunction

	// Drive one input transaction; hold it until the block takes it, then predict
	task automatic send(pfr_pkg::opcode_t op, logic [pfr_pkg::INDEX_W-1:0] idx,
			logic [pfr_pkg::COLOR_W-1:0] color, logic [pfr_pkg::COLOR_W-1:0] data);
		int        gap;
		src_item_t item;
		gap = draw_wait(in_calm);
		@(negedge clk);
		if (gap > 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.valid         <= 1'b1;
		pix_in.opcode        <= op;
		pix_in.palette_index <= idx;
		pix_in.palette_color <= color;
		pix_in.data_word     <= data;
		do @(posedge clk); while (pix_in.ready !== 1'b1);
		item.opcode        = op;
		item.palette_index = idx;
		item.palette_color = color;
		item.data_word     = data;
		sb.note_item(item);
		if (op == pfr_pkg::OP_PALETTE && !palette_written[idx]) begin
			palette_written[idx] = 1'b1;
			written_idx.push_back(idx);
		end
		// Data under the unused format is dropped; do not count it
		if (op == pfr_pkg::OP_PALETTE || cur_fmt != FMT_UNUSED) accepted++;
	endtask

	// Drop valid, drain every owed pixel, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		pix_in.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hold the write enable high across back-to-back writes; configure lowers it
	task automatic write_cfg(pfr_pkg::reg_idx_t idx, logic [pfr_pkg::DIM_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// Only call when idle: all three registers, format word may carry junk above bit 1
	task automatic configure(logic [pfr_pkg::DIM_W-1:0] fmt_word,
			logic [pfr_pkg::DIM_W-1:0] w, logic [pfr_pkg::DIM_W-1:0] h);
		write_cfg(pfr_pkg::REG_FORMAT, fmt_word);
		write_cfg(pfr_pkg::REG_WIDTH, w);
		write_cfg(pfr_pkg::REG_HEIGHT, h);
		@(negedge clk);
		cfg_we  <= 1'b0;
		cur_fmt = fmt_word[pfr_pkg::FMT_W-1:0];
	endtask

	// Output side: stall at random, check each pixel transaction against the oldest owed
	initial begin
		int     stall;
		pixel_t got;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(out_calm);
			@(negedge clk);
			if (stall > 0) begin
				pix_out.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pix_out.ready <= 1'b1;
			do @(posedge clk); while (pix_out.valid !== 1'b1);
			got = {pix_out.pixel_color, pix_out.last_of_item, pix_out.end_of_row,
				pix_out.end_of_frame};
			sb.check_pixel(got);
		end
	end

	initial begin
		int                            fmt_pick;
		int                            n;
		logic [pfr_pkg::FMT_W-1:0]     fmt;
		logic [pfr_pkg::DIM_W-1:0]     fmt_word;
		logic [pfr_pkg::DIM_W-1:0]     w;
		logic [pfr_pkg::DIM_W-1:0]     h;
		logic [pfr_pkg::INDEX_W-1:0]   idx;

		// Every input known from time zero
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = pfr_pkg::REG_FORMAT;
		cfg_data             = '0;
		pix_in.valid         = 1'b0;
		pix_in.opcode        = pfr_pkg::OP_PALETTE;
		pix_in.palette_index = '0;
		pix_in.palette_color = '0;
		pix_in.data_word     = '0;
		pix_out.ready        = 1'b0;
		cur_fmt              = pfr_pkg::FMT_MONO;
		accepted             = 0;
		in_calm              = 0;
		out_calm             = 0;
		cycle_count          = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset geometry, mono, 160 wide: full bytes only. High byte must be ignored.
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'hFF00);
		send(pfr_pkg::OP_DATA, 8'hFF, 16'hFFFF, 16'h00FF);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h5AA5);
		// Seed the palette; data_word is a don't-care on writes
		send(pfr_pkg::OP_PALETTE, 8'h00, 16'h0000, 16'hFFFF);
		send(pfr_pkg::OP_PALETTE, 8'hFF, 16'hFFFF, 16'h0000);
		send(pfr_pkg::OP_PALETTE, 8'hAA, 16'h5555, 16'h1234);
		send(pfr_pkg::OP_PALETTE, 8'h55, 16'hAAAA, 16'h0000);
		wait_idle();

		// Indexed, 3 x 2: exactly one whole frame
		configure(pfr_pkg::DIM_W'(pfr_pkg::FMT_INDEXED), pfr_pkg::DIM_W'(3),
			pfr_pkg::DIM_W'(2));
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h0000);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'hFFFF);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h12AA);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h0055);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h00FF);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'hAB00);
		wait_idle();

		// Direct, 1 x 1: every pixel closes row and frame
		configure(pfr_pkg::DIM_W'(pfr_pkg::FMT_DIRECT), pfr_pkg::DIM_W'(1),
			pfr_pkg::DIM_W'(1));
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h0000);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'hFFFF);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h8001);
		wait_idle();

		// Mono, 11 wide: second byte of each row is cut to three pixels
		configure(pfr_pkg::DIM_W'(pfr_pkg::FMT_MONO), pfr_pkg::DIM_W'(11),
			pfr_pkg::DIM_W'(2));
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h0081);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h00E0);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h003C);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h00FF);
		wait_idle();

		// Zero width and height act as one: a single pixel per byte
		configure(pfr_pkg::DIM_W'(pfr_pkg::FMT_MONO), '0, '0);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h0080);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h007F);
		wait_idle();

		// Unused format: data dropped, palette writes still land
		configure(pfr_pkg::DIM_W'(FMT_UNUSED), '1, '1);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'hFFFF);
		send(pfr_pkg::OP_PALETTE, 8'h01, 16'h1234, 16'h0000);
		wait_idle();

		// Read back the entry written under the unused format; oversize width saturates
		configure(pfr_pkg::DIM_W'(pfr_pkg::FMT_INDEXED), '1, '0);
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h0001);
		wait_idle();

		configure(pfr_pkg::DIM_W'(pfr_pkg::FMT_MONO), pfr_pkg::DIM_W'(pfr_pkg::MAX_WIDTH),
			pfr_pkg::DIM_W'(pfr_pkg::MAX_HEIGHT));
		send(pfr_pkg::OP_DATA, 8'h00, 16'h0000, 16'h00C3);
		wait_idle();

		// Random phases: fresh geometry each time, mostly small so rows and frames close
		accepted = 0;
		while (accepted < RANDOM_ITEMS) begin
			fmt_pick = $urandom_range(0, 9);
			fmt = (fmt_pick < 3) ? pfr_pkg::FMT_MONO : (fmt_pick < 6) ? pfr_pkg::FMT_INDEXED :
				(fmt_pick < 9) ? pfr_pkg::FMT_DIRECT : FMT_UNUSED;
			w = ($urandom_range(0, 9) == 0) ? odd_dim() :
				pfr_pkg::DIM_W'($urandom_range(1, 24));
			h = ($urandom_range(0, 9) == 0) ? odd_dim() :
				pfr_pkg::DIM_W'($urandom_range(1, 6));
			fmt_word = pfr_pkg::DIM_W'($urandom());
			fmt_word[pfr_pkg::FMT_W-1:0] = fmt;
			configure(fmt_word, w, h);
			n = $urandom_range(25, 45);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0) begin
					send(pfr_pkg::OP_PALETTE, pfr_pkg::INDEX_W'($urandom()),
						pfr_pkg::COLOR_W'($urandom()), pfr_pkg::COLOR_W'($urandom()));
				end else if (fmt == pfr_pkg::FMT_INDEXED) begin
					idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
					send(pfr_pkg::OP_DATA, pfr_pkg::INDEX_W'($urandom()),
						pfr_pkg::COLOR_W'($urandom()), {8'($urandom()), idx});
				end else begin
					send(pfr_pkg::OP_DATA, pfr_pkg::INDEX_W'($urandom()),
						pfr_pkg::COLOR_W'($urandom()), pfr_pkg::COLOR_W'($urandom()));
				end
			end
			wait_idle();
		end

		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
